// ===== sv/mdp_pkg.sv =====
package mdp_pkg;

  // Field widths fixed by the item format
  localparam int IDX_W  = 6;
  localparam int DATA_W = 32;

  // Default matrix order
  localparam int MATRIX_ORDER_DEF = 64;

  // Item kinds
  typedef enum logic [1:0] {
    KIND_WRITE_A = 2'd0,
    KIND_WRITE_B = 2'd1,
    KIND_COMPUTE = 2'd2
  } kind_e;

  // Sequencer to multiply-accumulate control
  typedef struct packed {
    logic clear;       // start a new sum
    logic term_valid;  // memory read data holds one term
  } mac_ctrl_t;

  // Multiply-accumulate status back to the sequencer
  typedef struct packed {
    logic busy;        // a product is still in flight
  } mac_stat_t;

endpackage

// ===== sv/mdp_if.sv =====
// Input channel: element writes and product requests
interface mdp_in_if;
  import mdp_pkg::*;

  logic                     valid;
  logic                     ready;
  logic [1:0]               kind;
  logic [IDX_W-1:0]         row_index;
  logic [IDX_W-1:0]         col_index;
  logic signed [DATA_W-1:0] element_value;

  modport source (output valid, kind, row_index, col_index, element_value, input ready);
  modport sink   (input valid, kind, row_index, col_index, element_value, output ready);
endinterface

// Output channel: one product element per transaction
interface mdp_out_if;
  import mdp_pkg::*;

  logic                     valid;
  logic                     ready;
  logic [IDX_W-1:0]         result_row;
  logic [IDX_W-1:0]         result_col;
  logic signed [DATA_W-1:0] dot_product;

  modport source (output valid, result_row, result_col, dot_product, input ready);
  modport sink   (input valid, result_row, result_col, dot_product, output ready);
endinterface

// ===== sv/mdp_matrix_mem.sv =====
module mdp_matrix_mem #(
  parameter int Depth = mdp_pkg::MATRIX_ORDER_DEF * mdp_pkg::MATRIX_ORDER_DEF,
  parameter int AddrW = $clog2(mdp_pkg::MATRIX_ORDER_DEF * mdp_pkg::MATRIX_ORDER_DEF)
) (
  input  logic                      clk_i,
  input  logic                      we_i,
  input  logic [AddrW-1:0]          waddr_i,
  input  logic [mdp_pkg::DATA_W-1:0] wdata_i,
  input  logic                      re_i,
  input  logic [AddrW-1:0]          raddr_i,
  output logic [mdp_pkg::DATA_W-1:0] rdata_o
);
  import mdp_pkg::*;

  logic [DATA_W-1:0] mem_q [Depth];
  logic [DATA_W-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== sv/mdp_mac.sv =====
module mdp_mac (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  mdp_pkg::mac_ctrl_t         ctrl_i,
  input  logic [mdp_pkg::DATA_W-1:0] a_data_i,
  input  logic [mdp_pkg::DATA_W-1:0] b_data_i,
  output mdp_pkg::mac_stat_t         stat_o,
  output logic [mdp_pkg::DATA_W-1:0] acc_o
);
  import mdp_pkg::*;

  logic [DATA_W-1:0]   prod_d, prod_q;
  logic                prod_vld_d, prod_vld_q;
  logic [DATA_W-1:0]   acc_d, acc_q;

  // Product stage: only the low word matters, the sum wraps mod 2^32
  assign prod_d     = a_data_i * b_data_i;
  assign prod_vld_d = ctrl_i.term_valid;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.term_valid) begin
      prod_q <= prod_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prod_vld_q <= 1'b0;
    end else begin
      prod_vld_q <= prod_vld_d;
    end
  end

  // Accumulate stage
  always_comb begin
    acc_d = acc_q;
    if (ctrl_i.clear) begin
      acc_d = '0;
    end else if (prod_vld_q) begin
      acc_d = acc_q + prod_q;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
  end

  assign stat_o.busy = prod_vld_q;
  assign acc_o       = acc_q;

endmodule

// ===== sv/matrix_element_dot_product.sv =====
// Element write (kind 0/1): taken while idle, no result.
// Product request (kind 2): terms are read one per cycle through the single
// read port of each matrix memory and summed; the result is loaded into the
// output register once the slot is free (an out-of-range index gives an empty
// sum); no new item is taken until then. Reset clears control and the output
// valid only; the matrix memories keep their contents, undefined until written.
module matrix_element_dot_product #(
  parameter int MatrixOrder = mdp_pkg::MATRIX_ORDER_DEF
) (
  input  logic clk_i,
  input  logic rst_ni,
  mdp_in_if.sink    in_i,
  mdp_out_if.source out_o
);
  import mdp_pkg::*;

  localparam int Depth = MatrixOrder * MatrixOrder;
  localparam int AddrW = $clog2(MatrixOrder * MatrixOrder);
  localparam int KW    = $clog2(MatrixOrder);
  localparam logic [KW-1:0] KLast = KW'(MatrixOrder - 1);

  // Sequencer states
  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_READ  = 2'd1;
  localparam logic [1:0] ST_FLUSH = 2'd2;

  logic [1:0]       state_d, state_q;
  logic [KW-1:0]    k_d, k_q;
  logic [AddrW-1:0] a_addr_d, a_addr_q;
  logic [AddrW-1:0] b_addr_d, b_addr_q;
  logic [IDX_W-1:0] row_d, row_q;
  logic [IDX_W-1:0] col_d, col_q;
  logic             rd_valid_q;

  logic             accept;
  logic             in_range;
  logic             we_a, we_b;
  logic [AddrW-1:0] wr_addr;
  logic [AddrW-1:0] a_base, b_base;
  logic             issue;
  logic             slot_free;
  logic             out_load;

  logic [DATA_W-1:0] a_rdata, b_rdata, acc;
  mac_ctrl_t         mac_ctrl;
  mac_stat_t         mac_stat;

  logic              out_valid_d, out_valid_q;
  logic [IDX_W-1:0]  out_row_q, out_col_q;
  logic [DATA_W-1:0] out_dot_q;

  // Input decode; new items only while no product is in progress
  assign in_i.ready = (state_q == ST_IDLE);
  assign accept     = in_i.valid && in_i.ready;
  assign in_range   = (32'(in_i.row_index) < 32'(MatrixOrder)) &&
                      (32'(in_i.col_index) < 32'(MatrixOrder));
  assign wr_addr    = AddrW'(32'(in_i.row_index) * 32'(MatrixOrder) + 32'(in_i.col_index));
  assign a_base     = AddrW'(32'(in_i.row_index) * 32'(MatrixOrder));
  assign b_base     = AddrW'(32'(in_i.col_index));
  assign we_a       = accept && in_range && (in_i.kind == KIND_WRITE_A);
  assign we_b       = accept && in_range && (in_i.kind == KIND_WRITE_B);

  assign slot_free  = !out_valid_q || out_o.ready;

  // Sequencer: walk row of A and column of B, one term per cycle
  always_comb begin
    state_d             = state_q;
    k_d                 = k_q;
    a_addr_d            = a_addr_q;
    b_addr_d            = b_addr_q;
    row_d               = row_q;
    col_d               = col_q;
    issue               = 1'b0;
    mac_ctrl.clear      = 1'b0;
    mac_ctrl.term_valid = rd_valid_q;
    out_load            = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (accept && (in_i.kind == KIND_COMPUTE)) begin
          mac_ctrl.clear = 1'b1;
          row_d          = in_i.row_index;
          col_d          = in_i.col_index;
          if (in_range) begin
            state_d  = ST_READ;
            k_d      = '0;
            a_addr_d = a_base;
            b_addr_d = b_base;
          end else begin
            // Out-of-range request: empty sum
            state_d = ST_FLUSH;
          end
        end
      end
      ST_READ: begin
        issue    = 1'b1;
        k_d      = k_q + 1'b1;
        a_addr_d = a_addr_q + 1'b1;
        b_addr_d = b_addr_q + AddrW'(MatrixOrder);
        if (k_q == KLast) begin
          state_d = ST_FLUSH;
        end
      end
      ST_FLUSH: begin
        // Wait until the last term is summed and the output slot is free
        if (!rd_valid_q && !mac_stat.busy && slot_free) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      rd_valid_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      rd_valid_q <= issue;
    end
  end

  always_ff @(posedge clk_i) begin
    k_q      <= k_d;
    a_addr_q <= a_addr_d;
    b_addr_q <= b_addr_d;
    row_q    <= row_d;
    col_q    <= col_d;
  end

  // Matrix memories
  mdp_matrix_mem #(
    .Depth (Depth),
    .AddrW (AddrW)
  ) u_mem_a (
    .clk_i   (clk_i),
    .we_i    (we_a),
    .waddr_i (wr_addr),
    .wdata_i (in_i.element_value),
    .re_i    (issue),
    .raddr_i (a_addr_q),
    .rdata_o (a_rdata)
  );

  mdp_matrix_mem #(
    .Depth (Depth),
    .AddrW (AddrW)
  ) u_mem_b (
    .clk_i   (clk_i),
    .we_i    (we_b),
    .waddr_i (wr_addr),
    .wdata_i (in_i.element_value),
    .re_i    (issue),
    .raddr_i (b_addr_q),
    .rdata_o (b_rdata)
  );

  // Multiply-accumulate
  mdp_mac u_mac (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctrl_i   (mac_ctrl),
    .a_data_i (a_rdata),
    .b_data_i (b_rdata),
    .stat_o   (mac_stat),
    .acc_o    (acc)
  );

  // Output register
  assign out_valid_d = out_load || (out_valid_q && !out_o.ready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_row_q <= row_q;
      out_col_q <= col_q;
      out_dot_q <= acc;
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.result_row  = out_row_q;
  assign out_o.result_col  = out_col_q;
  assign out_o.dot_product = out_dot_q;

`ifndef SYNTH
  // Memory reads only happen while a product is being computed
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_valid_q |-> (state_q != ST_IDLE))
    else $error("read data valid outside a product");

  // Accepting new items means the term pipeline has drained
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE) |-> (!rd_valid_q && !mac_stat.busy))
    else $error("pipeline busy while accepting items");

  // The last term read moves the sequencer to the drain state
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == ST_READ) && (k_q == KLast)) |=> (state_q == ST_FLUSH))
    else $error("term walk did not end after the last term");

  // A result is loaded only into a free output slot
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |-> slot_free)
    else $error("result overwrote a pending transaction");
`endif

endmodule

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 100ps

module testbench;
  import mdp_pkg::*;

  localparam int ORDER = MATRIX_ORDER_DEF;
  localparam logic [1:0] KIND_UNUSED = 2'd3;
  localparam int RANDOM_ITEMS = 370;
  localparam int IDLE_PCT = 19;
  localparam int STALL_LIMIT = 4000;
  localparam logic signed [DATA_W-1:0] S32_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [DATA_W-1:0] S32_MIN = 32'sh8000_0000;

  // One product element as it leaves the block
  typedef struct packed {
    logic [IDX_W-1:0]         row;
    logic [IDX_W-1:0]         col;
    logic signed [DATA_W-1:0] sum;
  } product_t;

  // One input transaction; has_sum marks a hand-computed product
  typedef struct packed {
    logic [1:0]               kind;
    logic [IDX_W-1:0]         row;
    logic [IDX_W-1:0]         col;
    logic signed [DATA_W-1:0] value;
    logic                     has_sum;
    logic signed [DATA_W-1:0] sum;
  } step_t;

  logic clk_i;
  logic rst_ni;

  mdp_in_if  in_if ();
  mdp_out_if out_if ();

  matrix_element_dot_product #(
    .MatrixOrder(ORDER)
  ) DUT (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_if),
    .out_o (out_if)
  );

  // Shadow copy of both matrices and which entries hold data
  logic signed [DATA_W-1:0] mat_a [ORDER][ORDER];
  logic signed [DATA_W-1:0] mat_b [ORDER][ORDER];
  bit       a_written [ORDER][ORDER];
  bit       b_written [ORDER][ORDER];
  int       a_row_fill [ORDER];
  int       b_col_fill [ORDER];
  product_t pending_products [$];
  product_t head;

  int error_cnt;
  int items_sent;
  int writes_sent;
  int requests_sent;
  int products_seen;
  int idle_cycles;
  bit calm;

  // Rows 0 and 63 of A and columns 0 and 63 of B are preloaded with ones
  step_t directed_steps [23] = '{
    '{KIND_COMPUTE, 6'd0,  6'd0,  32'sd0,  1'b1, 32'sd64},
    '{KIND_COMPUTE, 6'd63, 6'd63, 32'sd0,  1'b1, 32'sd64},
    '{KIND_COMPUTE, 6'd0,  6'd63, 32'sd0,  1'b1, 32'sd64},
    '{KIND_COMPUTE, 6'd63, 6'd0,  -32'sd1, 1'b1, 32'sd64},
    '{KIND_UNUSED,  6'd0,  6'd0,  S32_MIN, 1'b0, 32'sd0},
    '{KIND_UNUSED,  6'd63, 6'd63, -32'sd1, 1'b0, 32'sd0},
    '{KIND_COMPUTE, 6'd0,  6'd0,  S32_MAX, 1'b1, 32'sd64},
    '{KIND_WRITE_A, 6'd0,  6'd0,  32'sd0,  1'b0, 32'sd0},
    '{KIND_COMPUTE, 6'd0,  6'd0,  32'sd0,  1'b1, 32'sd63},
    '{KIND_WRITE_A, 6'd0,  6'd1,  S32_MAX, 1'b0, 32'sd0},
    '{KIND_COMPUTE, 6'd0,  6'd0,  32'sd0,  1'b0, 32'sd0},
    '{KIND_WRITE_B, 6'd1,  6'd0,  S32_MIN, 1'b0, 32'sd0},
    '{KIND_COMPUTE, 6'd0,  6'd0,  32'sd0,  1'b0, 32'sd0},
    '{KIND_WRITE_A, 6'd63, 6'd63, -32'sd1, 1'b0, 32'sd0},
    '{KIND_WRITE_B, 6'd63, 6'd63, -32'sd1, 1'b0, 32'sd0},
    '{KIND_COMPUTE, 6'd63, 6'd63, 32'sd0,  1'b0, 32'sd0},
    '{KIND_WRITE_B, 6'd63, 6'd0,  -32'sd1, 1'b0, 32'sd0},
    '{KIND_COMPUTE, 6'd63, 6'd0,  32'sd0,  1'b0, 32'sd0},
    '{KIND_WRITE_A, 6'd63, 6'd0,  S32_MIN, 1'b0, 32'sd0},
    '{KIND_WRITE_B, 6'd0,  6'd63, S32_MIN, 1'b0, 32'sd0},
    '{KIND_COMPUTE, 6'd63, 6'd63, 32'sd0,  1'b0, 32'sd0},
    '{KIND_WRITE_A, 6'd0,  6'd63, S32_MAX, 1'b0, 32'sd0},
    '{KIND_COMPUTE, 6'd0,  6'd63, 32'sd0,  1'b0, 32'sd0}
  };

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Row of A times column of B, wrapped to 32 bits
  function automatic logic signed [DATA_W-1:0] row_col_sum(int r, int c);
    logic [DATA_W-1:0] acc;
    acc = '0;
    for (int k = 0; k < ORDER; k++) acc += mat_a[r][k] * mat_b[k][c];
    return acc;
  endfunction

  function automatic step_t item_of(logic [1:0] kind, int row, int col,
                                    logic signed [DATA_W-1:0] value);
    step_t s;
    s = '0;
    s.kind  = kind;
    s.row   = row[IDX_W-1:0];
    s.col   = col[IDX_W-1:0];
    s.value = value;
    return s;
  endfunction

  // Element values biased toward the extremes
  function automatic logic signed [DATA_W-1:0] pick_value();
    case ($urandom_range(0, 9))
      0: return 32'sd0;
      1: return S32_MAX;
      2: return S32_MIN;
      3: return -32'sd1;
      4: return 32'sd1;
      5: return $signed($urandom_range(0, 200)) - 32'sd100;
      default: return $urandom;
    endcase
  endfunction

  // Update the shadow matrices for an accepted transaction; queue its product
  function automatic void apply_item(step_t s);
    product_t p;
    items_sent++;
    // with order 64 every 6-bit index is in range
    case (s.kind)
      KIND_WRITE_A: begin
        if (!a_written[s.row][s.col]) a_row_fill[s.row]++;
        a_written[s.row][s.col] = 1'b1;
        mat_a[s.row][s.col] = s.value;
        writes_sent++;
      end
      KIND_WRITE_B: begin
        if (!b_written[s.row][s.col]) b_col_fill[s.col]++;
        b_written[s.row][s.col] = 1'b1;
        mat_b[s.row][s.col] = s.value;
        writes_sent++;
      end
      KIND_COMPUTE: begin
        p.row = s.row;
        p.col = s.col;
        p.sum = s.has_sum ? s.sum : row_col_sum(s.row, s.col);
        pending_products.push_back(p);
        requests_sent++;
      end
      default: ;  // unused kind: nothing changes
    endcase
  endfunction

  // Drive one transaction, with random idle cycles ahead of it
  task automatic send_item(step_t s);
    while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
      in_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_if.valid         <= 1'b1;
    in_if.kind          <= s.kind;
    in_if.row_index     <= s.row;
    in_if.col_index     <= s.col;
    in_if.element_value <= s.value;
    do @(posedge clk_i); while (!in_if.ready);
    apply_item(s);
  endtask

  // Hold off the sender until every queued product has come back
  task automatic drain();
    in_if.valid <= 1'b0;
    do @(posedge clk_i); while (pending_products.size() != 0);
  endtask

  // Write one row of A or column of B; now and then stop part way
  task automatic fill_line(bit to_b);
    int open_lines[$];
    int line;
    int start;
    int len;
    for (int i = 0; i < ORDER; i++)
      if ((to_b ? b_col_fill[i] : a_row_fill[i]) < ORDER) open_lines.push_back(i);
    if (open_lines.size() == 0) return;
    line  = open_lines[$urandom_range(0, open_lines.size() - 1)];
    start = $urandom_range(0, ORDER - 1);
    len   = ($urandom_range(0, 3) == 0) ? $urandom_range(1, ORDER - 1) : ORDER;
    for (int n = 0; n < len; n++) begin
      if (to_b) send_item(item_of(KIND_WRITE_B, (start + n) % ORDER, line, pick_value()));
      else      send_item(item_of(KIND_WRITE_A, line, (start + n) % ORDER, pick_value()));
    end
  endtask

  // Product request on a fully written row of A and column of B
  task automatic send_request();
    int rows[$];
    int cols[$];
    for (int i = 0; i < ORDER; i++) begin
      if (a_row_fill[i] == ORDER) rows.push_back(i);
      if (b_col_fill[i] == ORDER) cols.push_back(i);
    end
    send_item(item_of(KIND_COMPUTE, rows[$urandom_range(0, rows.size() - 1)],
                      cols[$urandom_range(0, cols.size() - 1)], $urandom));
  endtask

  // Stimulus
  initial begin
    int rand_start;
    int pick;
    rst_ni                <= 1'b0;
    in_if.valid           <= 1'b0;
    in_if.kind            <= KIND_WRITE_A;
    in_if.row_index       <= '0;
    in_if.col_index       <= '0;
    in_if.element_value   <= '0;
    calm = 1'b0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // ones in the edge rows of A and edge columns of B
    for (int i = 0; i < ORDER; i++) begin
      send_item(item_of(KIND_WRITE_A, 0, i, 32'sd1));
      send_item(item_of(KIND_WRITE_A, ORDER - 1, i, 32'sd1));
      send_item(item_of(KIND_WRITE_B, i, 0, 32'sd1));
      send_item(item_of(KIND_WRITE_B, i, ORDER - 1, 32'sd1));
    end
    foreach (directed_steps[i]) send_item(directed_steps[i]);
    drain();

    // random mix: line fills, requests, stray writes, unused kinds
    rand_start = items_sent;
    while (items_sent - rand_start < RANDOM_ITEMS) begin
      calm = (items_sent - rand_start >= 150) && (items_sent - rand_start < 260);
      pick = $urandom_range(0, 99);
      if (pick < 2)       fill_line(1'b0);
      else if (pick < 4)  fill_line(1'b1);
      else if (pick < 50) send_request();
      else if (pick < 88)
        send_item(item_of($urandom_range(0, 1) ? KIND_WRITE_B : KIND_WRITE_A,
                          $urandom_range(0, ORDER - 1), $urandom_range(0, ORDER - 1),
                          pick_value()));
      else if (pick < 97)
        send_item(item_of(KIND_UNUSED, $urandom_range(0, 63), $urandom_range(0, 63),
                          $urandom));
      else drain();
    end
    calm = 1'b0;

    drain();
    repeat (ORDER + 8) @(posedge clk_i);
    if (pending_products.size() != 0) begin
      error_cnt++;
      $error("%0d products never arrived", pending_products.size());
    end
    $display("Sent %0d transactions: %0d element writes, %0d product requests.",
             items_sent, writes_sent, requests_sent);
    $display("Checked %0d products, edge indices, wraparound and unused kind.",
             products_seen);
    if (error_cnt == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

  // Receiver back-pressure
  always @(posedge clk_i) begin
    out_if.ready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
  end

  // Compare each product transaction with the oldest expectation
  always @(posedge clk_i) begin
    if (rst_ni && out_if.valid && out_if.ready) begin
      products_seen++;
      if (pending_products.size() == 0) begin
        error_cnt++;
        $error("unexpected product row %0d col %0d", out_if.result_row, out_if.result_col);
      end else begin
        head = pending_products.pop_front();
        if (out_if.result_row !== head.row) begin
          error_cnt++;
          $error("result_row: expected %0d, got %0d", head.row, out_if.result_row);
        end
        if (out_if.result_col !== head.col) begin
          error_cnt++;
          $error("result_col: expected %0d, got %0d", head.col, out_if.result_col);
        end
        if (out_if.dot_product !== head.sum) begin
          error_cnt++;
          $error("dot_product: expected %0d, got %0d", head.sum, out_if.dot_product);
        end
      end
    end
  end

  // Cycles with no transaction on either channel
  always @(posedge clk_i) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
  end

  // Watchdog
  initial begin
    while (idle_cycles < STALL_LIMIT) @(posedge clk_i);
    $error("no transaction for %0d cycles", STALL_LIMIT);
    $display("testbench: errors");
    $finish;
  end

endmodule

// ===== files.f =====
sv/mdp_pkg.sv
sv/mdp_if.sv
sv/mdp_matrix_mem.sv
sv/mdp_mac.sv
sv/matrix_element_dot_product.sv
tb/sv/testbench.sv
